// ----- rtl/pol_pkg.sv -----
// shared types and codes for the positional ordered list
package pol_pkg;

    // command codes
    localparam logic [1:0] CMD_INS_HEAD = 2'd0;
    localparam logic [1:0] CMD_INS_POS  = 2'd1;
    localparam logic [1:0] CMD_REMOVE   = 2'd2;
    localparam logic [1:0] CMD_READOUT  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture the incoming item
        logic exec;       // carry out the latched command
        logic read_step;  // stream one entry and rotate the list
        logic load;       // load the result register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;    // latched command is read out
        logic empty;      // list holds no entry
        logic read_last;  // current read out entry is the final one
    } dp_stat_t;

endpackage

// ----- rtl/pol_ctrl.sv -----
// controller state machine for the positional ordered list
module pol_ctrl
    import pol_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec = 1'b1;
                    // a non-empty read out emits its entries from the read state
                    if (stat.is_read && !stat.empty)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    cmd.read_step = 1'b1;
                    cmd.load      = 1'b1;
                    if (stat.read_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/pol_dpath.sv -----
// datapath: entry shift array, count, read index and result register
module pol_dpath
    import pol_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [1:0]  in_command,
    input  logic [31:0] in_value,
    input  logic [7:0]  in_position,
    output logic [1:0]  res_status,
    output logic [31:0] res_data,
    output logic [6:0]  res_index,
    output logic        res_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [31:0]   ent_reg  [DEPTH];
    logic [31:0]   ent_next [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] rd_idx_reg;
    logic [CW-1:0] rd_idx_next;

    logic [1:0]    op_reg;
    logic [31:0]   val_reg;
    logic [7:0]    pos_reg;

    logic [1:0]    status_reg;
    logic [31:0]   data_reg;
    logic [6:0]    index_reg;
    logic          last_reg;

    logic [8:0]    eff9;
    logic [8:0]    cnt9;
    logic          is_ins;
    logic          ins_ok;
    logic          ins_range_ok;
    logic          rem_ok;
    logic          full;
    logic [IW-1:0] rem_k;
    logic [31:0]   taken;

    logic [1:0]    st_calc;
    logic [31:0]   data_calc;

    assign cnt9   = 9'(count_reg);
    assign eff9   = (op_reg == CMD_INS_HEAD) ? 9'd1 : {1'b0, pos_reg};
    assign is_ins = (op_reg == CMD_INS_HEAD) || (op_reg == CMD_INS_POS);
    assign full   = (cnt9 == 9'(DEPTH));
    assign ins_range_ok = (eff9 != 9'd0) && (eff9 <= cnt9 + 9'd1);
    assign ins_ok = is_ins && ins_range_ok && !full;
    assign rem_ok = (op_reg == CMD_REMOVE) && (eff9 != 9'd0) && (eff9 <= cnt9);
    assign rem_k  = IW'(eff9 - 9'd1);
    assign taken  = ent_reg[rem_k];

    assign stat.is_read   = (op_reg == CMD_READOUT);
    assign stat.empty     = (count_reg == '0);
    assign stat.read_last = (9'(rd_idx_reg) + 9'd1 == cnt9);

    always_comb
    begin
        st_calc   = ST_OK;
        data_calc = '0;
        unique case (op_reg)
            CMD_INS_HEAD:
            begin
                st_calc = full ? ST_FULL : ST_OK;
            end
            CMD_INS_POS:
            begin
                // range check comes before the full check
                if (!ins_range_ok)
                begin
                    st_calc = ST_INVALID;
                end
                else if (full)
                begin
                    st_calc = ST_FULL;
                end
            end
            CMD_REMOVE:
            begin
                if (rem_ok)
                begin
                    data_calc = taken;
                end
                else
                begin
                    st_calc = ST_INVALID;
                end
            end
            CMD_READOUT:
            begin
                st_calc = ST_EMPTY;
            end
            default:
            begin
                st_calc = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_next[i] = ent_reg[i];
        end
        if (cmd.exec && ins_ok)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (9'(i) + 9'd1 == eff9)
                begin
                    ent_next[i] = val_reg;
                end
                else if ((9'(i) >= eff9) && (9'(i) <= cnt9))
                begin
                    ent_next[i] = ent_reg[(i == 0) ? 0 : i - 1];
                end
            end
            count_next = count_reg + CW'(1);
        end
        else if (cmd.exec && rem_ok)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if ((9'(i) + 9'd1 >= eff9) && (9'(i) + 9'd1 < cnt9))
                begin
                    ent_next[i] = ent_reg[(i == DEPTH - 1) ? i : i + 1];
                end
            end
            count_next = count_reg - CW'(1);
        end
        else if (cmd.exec)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.read_step)
        begin
            // rotate left by one; after count steps the list is back in place
            for (int i = 0; i < DEPTH; i++)
            begin
                if (9'(i) + 9'd1 < cnt9)
                begin
                    ent_next[i] = ent_reg[(i == DEPTH - 1) ? i : i + 1];
                end
                else if (9'(i) + 9'd1 == cnt9)
                begin
                    ent_next[i] = ent_reg[0];
                end
            end
            rd_idx_next = stat.read_last ? '0 : rd_idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
        if (cmd.latch)
        begin
            op_reg  <= in_command;
            val_reg <= in_value;
            pos_reg <= in_position;
        end
        if (cmd.load)
        begin
            if (cmd.read_step)
            begin
                status_reg <= ST_OK;
                data_reg   <= ent_reg[0];
                index_reg  <= 7'(9'(rd_idx_reg) + 9'd1);
                last_reg   <= stat.read_last;
            end
            else
            begin
                status_reg <= st_calc;
                data_reg   <= data_calc;
                index_reg  <= '0;
                last_reg   <= 1'b1;
            end
        end
    end

    assign res_status = status_reg;
    assign res_data   = data_reg;
    assign res_index  = index_reg;
    assign res_last   = last_reg;

endmodule

// ----- rtl/positional_ordered_list.sv -----
// positional ordered list: insert, remove and read out at one-based positions
// an item is taken in the idle state, executed in the execute state once the output register is free
// and its result is loaded into the result register; no new item is taken until the last one is done
// read out streams one entry per cycle through the rotating array while the output is not stalled
// reset: rst_n clears count and control, list contents are undefined until written
module positional_ordered_list
    import pol_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[39:32]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data[31:0], entry_index[38:32], zero[39]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] res_data;
    logic [6:0]  res_index;

    pol_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pol_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_command  (s_tuser),
        .in_value    (s_tdata[31:0]),
        .in_position (s_tdata[39:32]),
        .res_status  (m_tuser),
        .res_data    (res_data),
        .res_index   (res_index),
        .res_last    (m_tlast)
    );

    assign m_tdata = {1'b0, res_index, res_data};

endmodule

// ----- tb/positional_ordered_list_tb.sv -----
// testbench for the positional ordered list: directed table, then random checked commands
module positional_ordered_list_tb;
    import pol_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 16;
    localparam int CYCLE_CAP  = 300000;
    localparam int RANDOM_ITEMS = 228;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] data;
        logic [6:0]  entry_index;
        logic        last;
    } list_result_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] value;
        logic [7:0]  position;
        bit          fixed;       // expected result typed in below
        logic [1:0]  fixed_status;
        logic [31:0] fixed_data;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // value[31:0], position[39:32]
    logic [1:0]  s_tuser = '0;    // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // data[31:0], entry_index[38:32], zero[39]
    logic [1:0]  m_tuser;         // status[1:0]
    logic        m_tlast;

    logic signed [31:0] list_model[$];
    list_result_t       pending_results[$];
    stim_row_t          directed_rows[$];

    int fail_count  = 0;
    int items_sent  = 0;
    int cycle_cnt   = 0;
    int burst_left  = 1;
    bit draining    = 1'b0;

    positional_ordered_list #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_CAP);
        $display("%0t: timeout, %0d results still expected", $realtime, pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic void push_result(logic [1:0] status, logic [31:0] data,
                                        logic [6:0] entry_index, logic last);
        list_result_t r;
        r.status      = status;
        r.data        = data;
        r.entry_index = entry_index;
        r.last        = last;
        pending_results.push_back(r);
    endfunction

    // update the list copy and queue the results one command causes
    function automatic void apply_list_command(logic [1:0] cmd, logic [31:0] value,
                                               logic [7:0] position);
        int n;
        logic [31:0] taken;
        n = list_model.size();
        case (cmd)
            CMD_INS_HEAD:
            begin
                if (n >= DEPTH)
                    push_result(ST_FULL, '0, '0, 1'b1);
                else
                begin
                    list_model.push_front(value);
                    push_result(ST_OK, '0, '0, 1'b1);
                end
            end
            CMD_INS_POS:
            begin
                // range check wins over the full check
                if (position < 1 || position > n + 1)
                    push_result(ST_INVALID, '0, '0, 1'b1);
                else if (n >= DEPTH)
                    push_result(ST_FULL, '0, '0, 1'b1);
                else
                begin
                    list_model.insert(position - 1, value);
                    push_result(ST_OK, '0, '0, 1'b1);
                end
            end
            CMD_REMOVE:
            begin
                if (position < 1 || position > n)
                    push_result(ST_INVALID, '0, '0, 1'b1);
                else
                begin
                    taken = list_model[position - 1];
                    list_model.delete(position - 1);
                    push_result(ST_OK, taken, '0, 1'b1);
                end
            end
            default:
            begin
                if (n == 0)
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                        push_result(ST_OK, list_model[i], 7'(i + 1), i == n - 1);
            end
        endcase
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [31:0] value, logic [7:0] position,
                                    bit fixed, logic [1:0] fixed_status,
                                    logic [31:0] fixed_data);
        stim_row_t row;
        row.cmd          = cmd;
        row.value        = value;
        row.position     = position;
        row.fixed        = fixed;
        row.fixed_status = fixed_status;
        row.fixed_data   = fixed_data;
        directed_rows.push_back(row);
    endfunction

    // offer one item, wait for it to be taken, then keep or drop valid by the burst pattern
    task automatic send_item(stim_row_t row);
        int gap;
        s_tdata  <= {row.position, row.value};
        s_tuser  <= row.cmd;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_list_command(row.cmd, row.value, row.position);
        if (row.fixed)
        begin
            void'(pending_results.pop_back());
            push_result(row.fixed_status, row.fixed_data, '0, 1'b1);
        end
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            burst_left = ($urandom_range(5) == 0) ? 40 : $urandom_range(10, 1);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly valid commands; filling and draining phases swing the list between empty and full
    function automatic stim_row_t pick_command(bit filling);
        stim_row_t row;
        int n;
        int r;
        n = list_model.size();
        r = $urandom_range(99);
        row.fixed    = 1'b0;
        row.value    = pick_value();
        row.position = 8'($urandom_range(255));
        if (r < (filling ? 30 : 10))
            row.cmd = CMD_INS_HEAD;
        else if (r < (filling ? 70 : 30))
        begin
            row.cmd = CMD_INS_POS;
            if ($urandom_range(6) != 0)
                row.position = 8'($urandom_range(n + 1, 1));
            else
                row.position = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255, n + 2));
        end
        else if (r < 86)
        begin
            row.cmd = CMD_REMOVE;
            if (n > 0 && $urandom_range(6) != 0)
                row.position = 8'($urandom_range(n, 1));
            else
                row.position = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255, n + 1));
        end
        else
            row.cmd = CMD_READOUT;
        return row;
    endfunction

    initial
    begin
        bit filling;
        add_row(CMD_READOUT,  32'h0,          8'd0,   1, ST_EMPTY,   32'h0);
        add_row(CMD_REMOVE,   32'h0,          8'd1,   1, ST_INVALID, 32'h0);
        add_row(CMD_INS_POS,  32'h1234_5678,  8'd0,   1, ST_INVALID, 32'h0);
        add_row(CMD_INS_POS,  32'h1234_5678,  8'd2,   1, ST_INVALID, 32'h0);
        add_row(CMD_INS_HEAD, 32'h8000_0000,  8'd0,   1, ST_OK,      32'h0);
        add_row(CMD_INS_POS,  32'h7fff_ffff,  8'd2,   1, ST_OK,      32'h0);
        add_row(CMD_INS_POS,  32'hffff_ffff,  8'd1,   1, ST_OK,      32'h0);
        add_row(CMD_INS_POS,  32'hffff_ffff,  8'd255, 1, ST_INVALID, 32'h0);
        add_row(CMD_REMOVE,   32'h0,          8'd255, 1, ST_INVALID, 32'h0);
        add_row(CMD_READOUT,  32'h0,          8'd0,   0, ST_OK,      32'h0);
        add_row(CMD_REMOVE,   32'hffff_ffff,  8'd2,   1, ST_OK,      32'h8000_0000);
        add_row(CMD_REMOVE,   32'h0,          8'd0,   1, ST_INVALID, 32'h0);
        add_row(CMD_INS_POS,  32'h0,          8'd3,   0, ST_OK,      32'h0);
        // fill to capacity with inserts in the middle
        for (int i = 4; i <= DEPTH; i++)
            add_row(CMD_INS_POS, 32'h5a5a_0000 ^ (i * 32'h0101_0101), 8'(i / 2 + 1),
                    0, ST_OK, 32'h0);
        add_row(CMD_INS_HEAD, 32'h1,          8'd0,          1, ST_FULL,    32'h0);
        add_row(CMD_INS_POS,  32'h2,          8'(DEPTH + 1), 1, ST_FULL,    32'h0);
        add_row(CMD_INS_POS,  32'h3,          8'(DEPTH + 2), 1, ST_INVALID, 32'h0);
        add_row(CMD_READOUT,  32'h0,          8'd0,          0, ST_OK,      32'h0);
        add_row(CMD_REMOVE,   32'h0,          8'(DEPTH),     0, ST_OK,      32'h0);
        add_row(CMD_REMOVE,   32'h0,          8'd1,          0, ST_OK,      32'h0);
        add_row(CMD_INS_HEAD, 32'h0,          8'd0,          0, ST_OK,      32'h0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        filling = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (list_model.size() >= DEPTH)
                filling = 1'b0;
            else if (list_model.size() == 0)
                filling = 1'b1;
            send_item(pick_command(filling));
        end
        s_tvalid <= 1'b0;

        draining = 1'b1;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver: checks every taken item, stalls on its own pattern with two long hold-offs
    initial
    begin
        list_result_t want;
        int rx_cycle;
        int rx_mode;
        int hold_left;
        int holds_done;
        rx_cycle   = 0;
        rx_mode    = 0;
        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected item status=%0d data=%h index=%0d last=%b",
                             $realtime, m_tuser, m_tdata[31:0], m_tdata[38:32], m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== want.data)
                    begin
                        $display("%0t: data expected %h actual %h",
                                 $realtime, want.data, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[38:32] !== want.entry_index)
                    begin
                        $display("%0t: entry_index expected %0d actual %0d",
                                 $realtime, want.entry_index, m_tdata[38:32]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last expected %b actual %b",
                                 $realtime, want.last, m_tlast);
                        fail_count++;
                    end
                end
            end

            rx_cycle++;
            if (rx_cycle % 50 == 0)
                rx_mode = $urandom_range(2);
            if (hold_left == 0 && holds_done < 2 && items_sent >= 60 + holds_done * 120)
            begin
                hold_left = 150;
                holds_done++;
            end

            if (draining)
                m_tready <= 1'b1;
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(1));
                    default: m_tready <= (rx_cycle % 4 == 0);
                endcase
            end
        end
    end

endmodule
